// File: sv/svab_pkg.sv
// ---------------------------------------------------------------------------
// svab_pkg: shared types and constants for the shifted voxel address block
// Field widths, register indexes and boundary mode codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svab_pkg;

  // field widths
  localparam int IDX_W  = 24;
  localparam int CFG_W  = 9;
  localparam int MODE_W = 2;
  localparam int REG_W  = 3;

  // default largest axis length
  localparam int MAX_DIM_DEFAULT = 256;

  // boundary modes
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRAP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ZERO = 2'd2;

  // register indexes
  localparam logic [REG_W-1:0] REG_SIZE_X   = 3'd0;
  localparam logic [REG_W-1:0] REG_SIZE_Y   = 3'd1;
  localparam logic [REG_W-1:0] REG_SIZE_Z   = 3'd2;
  localparam logic [REG_W-1:0] REG_OFFSET_X = 3'd3;
  localparam logic [REG_W-1:0] REG_OFFSET_Y = 3'd4;
  localparam logic [REG_W-1:0] REG_OFFSET_Z = 3'd5;
  localparam logic [REG_W-1:0] REG_EDGE     = 3'd6;

endpackage

`default_nettype wire

// File: sv/shifted_voxel_address_boundary.sv
// ---------------------------------------------------------------------------
// shifted_voxel_address_boundary: shifted neighbor address with boundary rule
// Splits a linear voxel index, shifts each axis, applies the edge mode and
// rebuilds the source index.
// ---------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in        input      in_valid/in_stall  voxel_index
//  out       output     out_valid/out_stall source_index, zero_fill, index_invalid
//  cfg       input      cfg_write          cfg_index, cfg_data
//
//  one index per cycle while the pipe is not frozen; the path runs through the two 24-cell
//  divider chains (index / size_x, then / size_y) and three output stages
//  the whole pipe freezes while out_stall holds a waiting result
//  reset clears valid bits and the registers to their reset values
//  offset residues settle through their own free-running divider chains after a register write
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shifted_voxel_address_boundary #(
  parameter int MAX_DIM = svab_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [svab_pkg::IDX_W-1:0]       voxel_index,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [svab_pkg::IDX_W-1:0]       source_index,
  output logic                                  zero_fill,
  output logic                                  index_invalid,
  input  wire logic                             cfg_write,
  input  wire logic [svab_pkg::REG_W-1:0]       cfg_index,
  input  wire logic [svab_pkg::CFG_W-1:0]       cfg_data
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int TW = 2 * DW;
  localparam int PW = (3 * DW > svab_pkg::IDX_W) ? 3 * DW : svab_pkg::IDX_W;
  localparam int IW = svab_pkg::IDX_W;
  localparam int CW = svab_pkg::CFG_W;

  // configuration registers
  logic [CW-1:0]               size_x, size_y, size_z;
  logic [CW-1:0]               offset_x, offset_y, offset_z;
  logic [svab_pkg::MODE_W-1:0] edge_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x    <= CW'(1);
      size_y    <= CW'(1);
      size_z    <= CW'(1);
      offset_x  <= '0;
      offset_y  <= '0;
      offset_z  <= '0;
      edge_mode <= svab_pkg::MODE_STOP;
    end else if (cfg_write) begin
      case (cfg_index)
        svab_pkg::REG_SIZE_X:   size_x    <= cfg_data;
        svab_pkg::REG_SIZE_Y:   size_y    <= cfg_data;
        svab_pkg::REG_SIZE_Z:   size_z    <= cfg_data;
        svab_pkg::REG_OFFSET_X: offset_x  <= cfg_data;
        svab_pkg::REG_OFFSET_Y: offset_y  <= cfg_data;
        svab_pkg::REG_OFFSET_Z: offset_z  <= cfg_data;
        svab_pkg::REG_EDGE:     edge_mode <= cfg_data[svab_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective axis lengths, held to [1, MAX_DIM]
  function automatic logic [DW-1:0] eff_size(input logic [CW-1:0] s);
    logic [DW-1:0] r;
    if (s == '0) begin
      r = DW'(1);
    end else if (32'(s) > 32'(MAX_DIM)) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(s);
    end
    return r;
  endfunction

  logic [DW-1:0] nx, ny, nz;
  assign nx = eff_size(size_x);
  assign ny = eff_size(size_y);
  assign nz = eff_size(size_z);

  // offset residues modulo the axis length, free-running chains
  logic [CW-1:0] off_cfg  [0:2];
  logic [DW-1:0] off_n    [0:2];
  logic [DW-1:0] off_res  [0:2];
  logic [DW-1:0] roff     [0:2];

  assign off_cfg[0] = offset_x;
  assign off_cfg[1] = offset_y;
  assign off_cfg[2] = offset_z;
  assign off_n[0]   = nx;
  assign off_n[1]   = ny;
  assign off_n[2]   = nz;

  for (genvar a = 0; a < 3; a++) begin : g_off
    logic [CW-1:0] mag;
    logic [CW-1:0] quo;
    logic          sgn;
    assign mag = off_cfg[a][CW-1] ? CW'(-off_cfg[a]) : off_cfg[a];
    svab_div_chain #(.DW(DW), .NW(CW), .SW(1)) u_res (
      .clk      (clk),
      .rst      (rst),
      .en       (1'b1),
      .d        (off_n[a]),
      .num_in   (mag),
      .side_in  (off_cfg[a][CW-1]),
      .num_out  (quo),
      .rem_out  (off_res[a]),
      .side_out (sgn)
    );
    // negative offsets fold to n - r; quotient is not needed
    assign roff[a] = (sgn && off_res[a] != '0 && quo == quo) ? off_n[a] - off_res[a]
                                                             : off_res[a];
  end

  // pipe advance: everything moves unless a result waits on a stall
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // first chain: index / nx
  logic [IW-1:0] q1;
  logic [DW-1:0] x1;
  logic          v1;

  svab_div_chain #(.DW(DW), .NW(IW), .SW(1)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .d        (nx),
    .num_in   (voxel_index),
    .side_in  (in_valid),
    .num_out  (q1),
    .rem_out  (x1),
    .side_out (v1)
  );

  // second chain: (index / nx) / ny, carries x along
  logic [IW-1:0] zq;
  logic [DW-1:0] y2;
  logic [DW:0]   side2;

  svab_div_chain #(.DW(DW), .NW(IW), .SW(DW + 1)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .d        (ny),
    .num_in   (q1),
    .side_in  ({v1, x1}),
    .num_out  (zq),
    .rem_out  (y2),
    .side_out (side2)
  );

  // boundary rule per axis
  logic [DW-1:0] fx, fy, fz;
  logic          ox, oy, oz;

  svab_axis_fix #(.DW(DW)) u_fix_x (
    .c (side2[DW-1:0]), .off (offset_x), .roff (roff[0]), .n (nx),
    .mode (edge_mode), .coord (fx), .oob (ox)
  );
  svab_axis_fix #(.DW(DW)) u_fix_y (
    .c (y2), .off (offset_y), .roff (roff[1]), .n (ny),
    .mode (edge_mode), .coord (fy), .oob (oy)
  );
  svab_axis_fix #(.DW(DW)) u_fix_z (
    .c (zq[DW-1:0]), .off (offset_z), .roff (roff[2]), .n (nz),
    .mode (edge_mode), .coord (fz), .oob (oz)
  );

  // fix stage register
  logic          f_valid, f_inv, f_zf;
  logic [DW-1:0] f_x, f_y, f_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= side2[DW];
    end
    if (en) begin
      f_inv <= zq >= IW'(nz);
      f_zf  <= (zq < IW'(nz)) && (edge_mode == svab_pkg::MODE_ZERO) && (ox || oy || oz);
      f_x   <= fx;
      f_y   <= fy;
      f_z   <= fz;
    end
  end

  // recompose, first product: y + ny * z
  logic          r_valid, r_inv, r_zf;
  logic [DW-1:0] r_x;
  logic [TW-1:0] r_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (en) begin
      r_valid <= f_valid;
    end
    if (en) begin
      r_inv <= f_inv;
      r_zf  <= f_zf;
      r_x   <= f_x;
      r_t   <= TW'(f_y) + TW'(ny) * TW'(f_z);
    end
  end

  // recompose, second product: x + nx * t, into the output register
  logic [PW-1:0] s_wide;
  assign s_wide = PW'(r_x) + PW'(nx) * PW'(r_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= r_valid;
    end
    if (en) begin
      source_index  <= (r_inv || r_zf) ? '0 : s_wide[IW-1:0];
      zero_fill     <= r_zf;
      index_invalid <= r_inv;
    end
  end

  // checks
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(zero_fill && index_invalid))
    else $error("zero_fill and index_invalid both set");

  a_flag_zero_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (zero_fill || index_invalid)) |-> (source_index == '0))
    else $error("flagged result with nonzero source_index");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(source_index)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

// File: sv/svab_div_cell.sv
// ---------------------------------------------------------------------------
// svab_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder and emits one quotient bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svab_div_cell #(
  parameter int DW = 9,
  parameter int NW = 24,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic [DW-1:0] d,
  input  wire logic [DW-1:0] rem_in,
  input  wire logic [NW-1:0] num_in,
  input  wire logic [SW-1:0] side_in,
  output logic      [DW-1:0] rem,
  output logic      [NW-1:0] num,
  output logic      [SW-1:0] side
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;
  logic [NW-1:0] num_next;

  // trial subtract of the divisor
  always_comb begin
    trial    = {rem_in, num_in[NW-1]};
    diff     = trial - {1'b0, d};
    ge       = trial >= {1'b0, d};
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    num_next = {num_in[NW-2:0], ge};
  end

  // step register
  always_ff @(posedge clk) begin
    if (rst) begin
      side <= '0;
    end else if (en) begin
      side <= side_in;
    end
    if (en) begin
      rem <= rem_next;
      num <= num_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/svab_div_chain.sv
// ---------------------------------------------------------------------------
// svab_div_chain: row of division cells
// One quotient bit per cell; quotient ends in num_out, remainder in rem_out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svab_div_chain #(
  parameter int DW = 9,
  parameter int NW = 24,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic [DW-1:0] d,
  input  wire logic [NW-1:0] num_in,
  input  wire logic [SW-1:0] side_in,
  output logic      [NW-1:0] num_out,
  output logic      [DW-1:0] rem_out,
  output logic      [SW-1:0] side_out
);

  logic [DW-1:0] rem_w  [0:NW];
  logic [NW-1:0] num_w  [0:NW];
  logic [SW-1:0] side_w [0:NW];

  assign rem_w[0]  = '0;
  assign num_w[0]  = num_in;
  assign side_w[0] = side_in;

  // cells, one per dividend bit
  for (genvar k = 0; k < NW; k++) begin : g_cell
    svab_div_cell #(.DW(DW), .NW(NW), .SW(SW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .d       (d),
      .rem_in  (rem_w[k]),
      .num_in  (num_w[k]),
      .side_in (side_w[k]),
      .rem     (rem_w[k+1]),
      .num     (num_w[k+1]),
      .side    (side_w[k+1])
    );
  end

  assign num_out  = num_w[NW];
  assign rem_out  = rem_w[NW];
  assign side_out = side_w[NW];

endmodule

`default_nettype wire

// File: sv/svab_axis_fix.sv
// ---------------------------------------------------------------------------
// svab_axis_fix: boundary rule for one axis
// Adds the offset and clamps, wraps or flags a coordinate outside the axis.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svab_axis_fix #(
  parameter int DW = 9
) (
  input  wire logic [DW-1:0]               c,
  input  wire logic [svab_pkg::CFG_W-1:0]  off,
  input  wire logic [DW-1:0]               roff,
  input  wire logic [DW-1:0]               n,
  input  wire logic [svab_pkg::MODE_W-1:0] mode,
  output logic      [DW-1:0]               coord,
  output logic                             oob
);

  localparam int VW = ((DW > svab_pkg::CFG_W) ? DW : svab_pkg::CFG_W) + 2;

  logic signed [VW-1:0] v;
  logic        [DW:0]   w;
  logic        [DW:0]   wf;
  logic                 neg;

  always_comb begin
    // shifted coordinate
    v   = $signed(VW'(c)) + VW'($signed(off));
    neg = v[VW-1];
    oob = neg || (v >= $signed(VW'(n)));
    // wrap with the offset already reduced modulo n
    w  = (DW+1)'(c) + (DW+1)'(roff);
    wf = (w >= (DW+1)'(n)) ? w - (DW+1)'(n) : w;
    if (!oob) begin
      coord = v[DW-1:0];
    end else if (mode == svab_pkg::MODE_WRAP) begin
      coord = wf[DW-1:0];
    end else if (neg) begin
      coord = '0;
    end else begin
      coord = n - DW'(1);
    end
  end

endmodule

`default_nettype wire

// File: dv/svab_checker.sv
// ---------------------------------------------------------------------------
// svab_checker: address predictor and result scoreboard
// Watches the config port and both channels. It predicts each source index
// from its own register copy and compares every output transfer in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module svab_checker
  import svab_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [IDX_W-1:0] voxel_index,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [IDX_W-1:0] source_index,
  input  logic             zero_fill,
  input  logic             index_invalid,
  input  logic             cfg_write,
  input  logic [REG_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [IDX_W-1:0] src;
    logic             zfill;
    logic             invalid;
  } addr_result_t;

  logic [CFG_W-1:0]  sz_x, sz_y, sz_z, off_x, off_y, off_z;
  logic [MODE_W-1:0] mode;
  addr_result_t      expected_addrs[$];

  // size register as the block uses it
  function automatic longint axis_len(logic [CFG_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
    return s;
  endfunction

  // boundary rule for one axis; returns 0 when zero fill applies
  function automatic bit fold_axis(inout longint c, input longint n);
    if (c >= 0 && c < n) return 1;
    if (mode == MODE_ZERO) return 0;
    if (mode == MODE_WRAP) begin
      c = c % n;
      if (c < 0) c = c + n;
    end else begin
      c = (c < 0) ? 0 : n - 1;
    end
    return 1;
  endfunction

  function automatic addr_result_t shifted_addr(logic [IDX_W-1:0] vi);
    addr_result_t r;
    longint nx, ny, nz, x, y, z, idx;
    nx = axis_len(sz_x);
    ny = axis_len(sz_y);
    nz = axis_len(sz_z);
    idx = vi;
    r = '0;
    if (idx >= nx * ny * nz) begin
      r.invalid = 1'b1;
      return r;
    end
    x = idx % nx + longint'($signed(off_x));
    y = (idx / nx) % ny + longint'($signed(off_y));
    z = idx / (nx * ny) + longint'($signed(off_z));
    if (!fold_axis(x, nx) || !fold_axis(y, ny) || !fold_axis(z, nz)) begin
      r.zfill = 1'b1;
      return r;
    end
    r.src = IDX_W'(x + nx * (y + ny * z));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // inputs only move at the rising edge, so the falling edge sees the
  // values that the next rising edge will act on
  always @(negedge clk) begin
    addr_result_t want;
    if (rst) begin
      sz_x = 1; sz_y = 1; sz_z = 1;
      off_x = 0; off_y = 0; off_z = 0;
      mode = MODE_STOP;
      expected_addrs.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_SIZE_X:   sz_x = cfg_data;
          REG_SIZE_Y:   sz_y = cfg_data;
          REG_SIZE_Z:   sz_z = cfg_data;
          REG_OFFSET_X: off_x = cfg_data;
          REG_OFFSET_Y: off_y = cfg_data;
          REG_OFFSET_Z: off_z = cfg_data;
          REG_EDGE:     mode = cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
      // input transfer
      if (in_valid && !in_stall) expected_addrs.push_back(shifted_addr(voxel_index));
      // output transfer
      if (out_valid && !out_stall) begin
        if (expected_addrs.size() == 0) begin
          // result with nothing outstanding
          report_mismatch("outstanding results", 1, 0);
        end else begin
          want = expected_addrs.pop_front();
          if (source_index !== want.src)
            report_mismatch("source_index", source_index, want.src);
          if (zero_fill !== want.zfill)
            report_mismatch("zero_fill", zero_fill, want.zfill);
          if (index_invalid !== want.invalid)
            report_mismatch("index_invalid", index_invalid, want.invalid);
        end
      end
    end
    pending = expected_addrs.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

// File: dv/shifted_voxel_address_boundary_test.sv
// ---------------------------------------------------------------------------
// shifted_voxel_address_boundary_test: stimulus and verdict
// Runs directed corner configurations, then random volumes, offsets and
// edge modes under varied idling, with a long output hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module shifted_voxel_address_boundary_test;
  import svab_pkg::*;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [IDX_W-1:0] voxel_index;
  logic             out_valid;
  logic             out_stall;
  logic [IDX_W-1:0] source_index;
  logic             zero_fill;
  logic             index_invalid;
  logic             cfg_write;
  logic [REG_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               fail_count;
  int               pending;

  int  tx_idle_pct;
  int  rx_stall_pct;
  int  hold_requests;
  int  holds_done;
  int  hold_left;
  logic in_stall_seen;

  shifted_voxel_address_boundary DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .voxel_index(voxel_index),
    .out_valid(out_valid), .out_stall(out_stall), .source_index(source_index),
    .zero_fill(zero_fill), .index_invalid(index_invalid),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  svab_checker scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .voxel_index(voxel_index),
    .out_valid(out_valid), .out_stall(out_stall), .source_index(source_index),
    .zero_fill(zero_fill), .index_invalid(index_invalid),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // stall as seen just before the coming edge
  always @(negedge clk) in_stall_seen = in_stall;

  // receiver: random stall plus requested long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      holds_done = 0;
    end else begin
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  function automatic longint vol_of(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b,
                                    logic [CFG_W-1:0] c);
    longint n[3];
    n[0] = a; n[1] = b; n[2] = c;
    foreach (n[i]) begin
      if (n[i] == 0) n[i] = 1;
      if (n[i] > MAX_DIM_DEFAULT) n[i] = MAX_DIM_DEFAULT;
    end
    return n[0] * n[1] * n[2];
  endfunction

  // one index transfer, with an optional idle gap ahead of it
  task automatic send_index(logic [IDX_W-1:0] vi);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    voxel_index <= vi;
    @(posedge clk);
    while (in_stall_seen) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // all seven registers, only while the pipe is empty
  task automatic load_regs(logic [CFG_W-1:0] sx, logic [CFG_W-1:0] sy, logic [CFG_W-1:0] sz,
                           logic [CFG_W-1:0] ox, logic [CFG_W-1:0] oy, logic [CFG_W-1:0] oz,
                           logic [MODE_W-1:0] md);
    logic [CFG_W-1:0] vals[7];
    vals = '{sx, sy, sz, ox, oy, oz, CFG_W'(md)};
    drain();
    for (int i = 0; i < 7; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    // let the offset residues settle
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] rand_size;
    if ($urandom_range(99) < 80) return CFG_W'($urandom_range(1, 16));
    return CFG_W'($urandom_range(0, 511));
  endfunction

  function automatic logic [CFG_W-1:0] rand_offset(logic [CFG_W-1:0] s);
    int lim;
    lim = (s > 4) ? s : 4;
    if ($urandom_range(99) < 70) return CFG_W'($urandom_range(0, 2 * lim) - lim);
    return CFG_W'($urandom);
  endfunction

  initial begin
    logic [IDX_W-1:0] corners[6];
    logic [CFG_W-1:0] sx, sy, sz;
    longint vol;
    int wait_cycles;
    rst = 1'b1;
    in_valid = 1'b0;
    voxel_index = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_requests = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset volume is a single voxel
    send_index(24'd0);
    send_index(24'd1);
    send_index(24'hFFFFFF);

    // directed corners: clamp, wrap, zero fill, mode three with odd sizes, full-size wrap
    corners = '{24'd0, 24'd1, 24'd59, 24'd60, 24'hFFFFFF, 24'h800000};
    load_regs(9'd4, 9'd3, 9'd5, 9'd1, -9'sd1, 9'd2, MODE_STOP);
    foreach (corners[i]) send_index(corners[i]);
    load_regs(9'd4, 9'd3, 9'd5, -9'sd5, 9'd7, 9'h100, MODE_WRAP);
    foreach (corners[i]) send_index(corners[i]);
    load_regs(9'd4, 9'd3, 9'd5, 9'd1, 9'd0, 9'd0, MODE_ZERO);
    foreach (corners[i]) send_index(corners[i]);
    load_regs(9'd0, 9'd300, 9'd511, 9'd255, -9'sd255, 9'd0, 2'd3);
    send_index(24'd0);
    send_index(24'd65535);
    send_index(24'd65536);
    load_regs(9'd256, 9'd256, 9'd256, 9'd255, -9'sd255, 9'h100, MODE_WRAP);
    send_index(24'hFFFFFF);
    send_index(24'd0);

    // random phases
    for (int ph = 0; ph < 13; ph++) begin
      sx = rand_size();
      sy = rand_size();
      sz = rand_size();
      load_regs(sx, sy, sz, rand_offset(sx), rand_offset(sy), rand_offset(sz),
                MODE_W'($urandom_range(0, 3)));
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
        default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
      endcase
      vol = vol_of(sx, sy, sz);
      for (int k = 0; k < 105; k++) begin
        if (ph == 4 && k == 10) hold_requests++;
        if ($urandom_range(99) < 70)
          send_index(IDX_W'($urandom_range(0, int'(vol - 1))));
        else if ($urandom_range(99) < 50)
          send_index(IDX_W'(vol + $urandom_range(0, 3)));
        else
          send_index(IDX_W'($urandom));
      end
      tx_idle_pct = 0;
      rx_stall_pct = 0;
    end

    // wait out the pipe, bounded
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
sv/svab_pkg.sv
sv/svab_div_cell.sv
sv/svab_div_chain.sv
sv/svab_axis_fix.sv
sv/shifted_voxel_address_boundary.sv
dv/svab_checker.sv
dv/shifted_voxel_address_boundary_test.sv
